// ----- hw/rtl/orl_pkg.sv -----
// ----------------------------------------------------------------------------
// orl_pkg
// Shared types, character codes and helpers for the object record loader.
// ----------------------------------------------------------------------------
`default_nettype none

package orl_pkg;

  // Field widths
  localparam int unsigned CharW   = 8;
  localparam int unsigned AddrW   = 24;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PosW    = 4;
  localparam int unsigned NameLen = 6;
  localparam int unsigned NameW   = NameLen * CharW;
  localparam int unsigned OutW    = StatusW + AddrW + 2 * CharW;
  localparam int unsigned OutBusW = ((OutW + 7) / 8) * 8;

  // Character codes
  localparam logic [CharW-1:0] ChH      = 8'h48;  // 'H'
  localparam logic [CharW-1:0] ChT      = 8'h54;  // 'T'
  localparam logic [CharW-1:0] ChE      = 8'h45;  // 'E'
  localparam logic [CharW-1:0] ChDollar = 8'h24;  // '$'
  localparam logic [CharW-1:0] ChCaret  = 8'h5E;  // '^'
  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChTab    = 8'h09;
  localparam logic [CharW-1:0] ChCr     = 8'h0D;
  localparam logic [CharW-1:0] ChLf     = 8'h0A;

  // Record positions
  localparam logic [PosW-1:0] PosNameFirst = 4'd2;
  localparam logic [PosW-1:0] PosNameLast  = 4'd7;
  localparam logic [PosW-1:0] PosData      = 4'd12;

  typedef enum logic [2:0] {
    PH_AWAIT_HDR,
    PH_HDR,
    PH_REC_START,
    PH_TEXT,
    PH_SKIP,
    PH_STOPPED
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_BYTE     = 3'd0,
    ST_INVALID  = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_END      = 3'd3,
    ST_ACCEPT   = 3'd4
  } status_e;

  typedef struct packed {
    logic [CharW-1:0] low_char;
    logic [CharW-1:0] high_char;
    logic [AddrW-1:0] load_address;
    status_e          status;
  } result_t;

  // Record separator test
  function automatic logic is_sep(input logic [CharW-1:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChLf);
  endfunction

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_digit(input logic [CharW-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/object_record_absolute_loader_unit.sv -----
// Path: each character is held in the input register, its result in the result register.
// Throughput: one character per cycle while the result register has room.
// Input register, parser state and result register hold their contents while m_axis stalls.
// Reset: asynchronous, active low; parser waits for a header, name clears to 0.
// ----------------------------------------------------------------------------
// object_record_absolute_loader_unit
// Absolute loader for a text object program fed one character per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module object_record_absolute_loader_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Configuration: expected program name, first character in top byte
  input  wire logic                        cfg_we_i,
  input  wire logic [orl_pkg::NameW-1:0]   cfg_wdata_i,
  // Slave side
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,   // [7:0] char_in
  // Master side
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [2:0] status, [26:3] load_address, [34:27] high_char, [42:35] low_char,
  // [47:43] zero
  output logic [orl_pkg::OutBusW-1:0]      m_axis_tdata
);
  import orl_pkg::*;

  logic             char_valid;
  logic [CharW-1:0] char_q;
  logic             step;
  logic             out_space;
  logic             has_result;
  result_t          result;
  result_t          out_result;

  // A character is processed when the result register can take its result
  assign step = char_valid && out_space;

  orl_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_char_i    (s_axis_tdata),
    .char_valid_o (char_valid),
    .char_o       (char_q),
    .char_take_i  (step)
  );

  orl_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .step_i       (step),
    .char_i       (char_q),
    .has_result_o (has_result),
    .result_o     (result)
  );

  orl_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (step && has_result),
    .result_i     (result),
    .space_o      (out_space),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_result_o (out_result)
  );

  assign m_axis_tdata = {{(OutBusW - OutW){1'b0}}, out_result};

endmodule

`default_nettype wire

// ----- hw/rtl/orl_in_stage.sv -----
// ----------------------------------------------------------------------------
// orl_in_stage
// Input register: captures one character per transfer, drains into the core.
// ----------------------------------------------------------------------------
`default_nettype none

module orl_in_stage (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [orl_pkg::CharW-1:0] in_char_i,
  output logic                          char_valid_o,
  output logic [orl_pkg::CharW-1:0]     char_o,
  input  wire logic                     char_take_i
);
  import orl_pkg::*;

  logic             valid_q, valid_d;
  logic [CharW-1:0] char_q;

  // Free when empty or when the held character moves on this cycle
  assign in_ready_o = !valid_q || char_take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (char_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= in_char_i;
    end
  end

  assign char_valid_o = valid_q;
  assign char_o       = char_q;

endmodule

`default_nettype wire

// ----- hw/rtl/orl_core.sv -----
// ----------------------------------------------------------------------------
// orl_core
// Record parser state and per-character update: header name check, T record
// address decode, byte pairing, end of program.
// ----------------------------------------------------------------------------
`default_nettype none

module orl_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [orl_pkg::NameW-1:0] cfg_wdata_i,
  input  wire logic                      step_i,
  input  wire logic [orl_pkg::CharW-1:0] char_i,
  output logic                           has_result_o,
  output orl_pkg::result_t               result_o
);
  import orl_pkg::*;

  logic [NameW-1:0] name_q;
  phase_e           phase_q, phase_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             differs_q, differs_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic             frozen_q, frozen_d;
  logic [CharW-1:0] pend_char_q, pend_char_d;
  logic             pend_valid_q, pend_valid_d;
  logic             term_q, term_d;

  logic             sep;
  logic [4:0]       hex;
  logic [PosW-1:0]  name_idx;
  logic [CharW-1:0] name_at_pos;
  logic [PosW-1:0]  tail_start;
  logic             tail_differs;
  logic             diff_next;

  // Character compared at the current header position
  assign name_idx    = PosNameLast - pos_q;
  assign name_at_pos = name_q[name_idx[2:0]*CharW +: CharW];
  assign tail_start  = (pos_q < PosNameFirst) ? '0 : pos_q - PosNameFirst;
  assign sep         = is_sep(char_i);
  assign hex         = hex_digit(char_i);

  // Missing name characters of a short header compare as zero
  always_comb begin
    tail_differs = 1'b0;
    for (int k = 0; k < NameLen; k++) begin
      if (PosW'(k) >= tail_start && name_q[(NameLen-1-k)*CharW +: CharW] != '0) begin
        tail_differs = 1'b1;
      end
    end
  end

  // Next state and result
  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    differs_d    = differs_q;
    addr_d       = addr_q;
    frozen_d     = frozen_q;
    pend_char_d  = pend_char_q;
    pend_valid_d = pend_valid_q;
    term_d       = term_q;
    has_result_o = 1'b0;
    result_o     = '{low_char: '0, high_char: '0, load_address: '0, status: ST_BYTE};
    diff_next    = differs_q;

    unique case (phase_q)
      PH_AWAIT_HDR: begin
        if (!sep) begin
          if (char_i != ChH) begin
            phase_d         = PH_STOPPED;
            has_result_o    = 1'b1;
            result_o.status = ST_INVALID;
          end else begin
            phase_d   = PH_HDR;
            pos_d     = 4'd1;
            differs_d = 1'b0;
          end
        end
      end

      PH_HDR: begin
        if (sep) begin
          diff_next    = differs_q || tail_differs;
          differs_d    = diff_next;
          has_result_o = 1'b1;
          if (diff_next) begin
            phase_d         = PH_STOPPED;
            result_o.status = ST_MISMATCH;
          end else begin
            phase_d         = PH_REC_START;
            result_o.status = ST_ACCEPT;
          end
        end else begin
          if (pos_q >= PosNameFirst && pos_q <= PosNameLast && char_i != name_at_pos) begin
            diff_next = 1'b1;
          end
          differs_d = diff_next;
          pos_d     = pos_q + 4'd1;
          if (pos_q == PosNameLast) begin
            has_result_o = 1'b1;
            if (diff_next) begin
              phase_d         = PH_STOPPED;
              result_o.status = ST_MISMATCH;
            end else begin
              phase_d         = PH_SKIP;
              result_o.status = ST_ACCEPT;
            end
          end
        end
      end

      PH_REC_START: begin
        if (!sep) begin
          if (char_i == ChE) begin
            phase_d         = PH_STOPPED;
            has_result_o    = 1'b1;
            result_o.status = ST_END;
          end else if (char_i == ChT) begin
            phase_d      = PH_TEXT;
            pos_d        = 4'd1;
            addr_d       = '0;
            frozen_d     = 1'b0;
            pend_char_d  = '0;
            pend_valid_d = 1'b0;
            term_d       = 1'b0;
          end else begin
            phase_d = PH_SKIP;
          end
        end
      end

      PH_TEXT: begin
        if (sep) begin
          pend_valid_d = 1'b0;
          pend_char_d  = '0;
          phase_d      = PH_REC_START;
        end else if (pos_q < PosData) begin
          // Address field, frozen by the first non-hex character
          if (pos_q >= PosNameFirst && pos_q <= PosNameLast && !frozen_q) begin
            if (!hex[4]) begin
              frozen_d = 1'b1;
            end else begin
              addr_d = {addr_q[AddrW-5:0], hex[3:0]};
            end
          end
          pos_d = pos_q + 4'd1;
        end else if (!term_q) begin
          if (pend_valid_q) begin
            has_result_o          = 1'b1;
            result_o.status       = ST_BYTE;
            result_o.load_address = addr_q;
            result_o.high_char    = pend_char_q;
            result_o.low_char     = char_i;
            pend_valid_d          = 1'b0;
            pend_char_d           = '0;
            addr_d                = addr_q + 24'd1;
          end else if (char_i == ChDollar) begin
            term_d = 1'b1;
          end else if (char_i != ChCaret) begin
            pend_char_d  = char_i;
            pend_valid_d = 1'b1;
          end
        end
      end

      PH_SKIP: begin
        if (sep) begin
          phase_d = PH_REC_START;
        end
      end

      default: begin
      end
    endcase
  end

  // Configured name
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_q <= '0;
    end else if (cfg_we_i) begin
      name_q <= cfg_wdata_i;
    end
  end

  // Parser state, advances once per character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_AWAIT_HDR;
      pos_q        <= '0;
      differs_q    <= 1'b0;
      addr_q       <= '0;
      frozen_q     <= 1'b0;
      pend_char_q  <= '0;
      pend_valid_q <= 1'b0;
      term_q       <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      differs_q    <= differs_d;
      addr_q       <= addr_d;
      frozen_q     <= frozen_d;
      pend_char_q  <= pend_char_d;
      pend_valid_q <= pend_valid_d;
      term_q       <= term_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/orl_out_reg.sv -----
// ----------------------------------------------------------------------------
// orl_out_reg
// Result register on the master side; holds a result until transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module orl_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire orl_pkg::result_t result_i,
  output logic                  space_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output orl_pkg::result_t      out_result_o
);
  import orl_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  // Room for a new result when empty or draining this cycle
  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_result_o = result_q;

endmodule

`default_nettype wire
